/* hdl/plt_pkg.sv */
`timescale 1ns / 1ps

package plt_pkg;

  // Fixed widths of the Q16.16 datapath.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MAG_W     = DATA_W + 1;   // magnitude of a 33-bit difference
  localparam int unsigned PROD_W    = 2 * DATA_W + 1; // product of two magnitudes
  localparam int unsigned REM_W     = MAG_W + 1;
  localparam int unsigned QUO_W     = 41;           // quotient is capped at 2^40
  localparam int unsigned MUL_SPLIT = 16;           // low slice of the second factor
  localparam int unsigned MUL_HI_W  = MAG_W - MUL_SPLIT;
  localparam int unsigned MUL_P_W   = MAG_W + MUL_HI_W;
  localparam int unsigned CNT_W     = $clog2(PROD_W);
  localparam int unsigned LEN_W     = 6;

  localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, {(QUO_W-1){1'b0}}};
  localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 6'd2;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;
  localparam logic [1:0] REGION_WRITE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK0,
    S_CHKN,
    S_MID,
    S_HI,
    S_LO,
    S_SEG,
    S_P1,
    S_P2,
    S_DIV,
    S_DONE
  } plt_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_DIV
  } plt_md_phase_e;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
    logic [MAG_W-1:0] d_mag;
  } plt_md_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } plt_md_rsp_t;

endpackage

/* hdl/plt_table.sv */
`timescale 1ns / 1ps

module plt_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  // Each word holds the breakpoint in the upper half and its value in the lower half.
  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/plt_muldiv.sv */
`timescale 1ns / 1ps

module plt_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plt_pkg::plt_md_req_t req_i,
  output plt_pkg::plt_md_rsp_t rsp_o
);

  import plt_pkg::*;

  plt_md_phase_e phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [MAG_W-1:0]  a_q, a_d, b_q, b_d, d_q, d_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              big_q, big_d;

  logic [MUL_HI_W-1:0] mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    div_ext;
  logic                ge;

  // One multiplier, used for the low and then the high slice of the second factor.
  assign mul_b = (phase_q == MD_MUL_LO) ? {1'b0, b_q[MUL_SPLIT-1:0]}
                                         : b_q[MAG_W-1:MUL_SPLIT];
  assign mul_p = a_q * mul_b;

  // Restoring division step, one quotient bit per cycle.
  assign div_ext   = {1'b0, d_q};
  assign rem_shift = {rem_q[REM_W-2:0], prod_q[PROD_W-1]};
  assign ge        = rem_shift >= div_ext;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    big_d   = big_q;
    unique case (phase_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a_mag;
          b_d     = req_i.b_mag;
          d_d     = req_i.d_mag;
          phase_d = MD_MUL_LO;
        end
      end
      MD_MUL_LO: begin
        prod_d  = PROD_W'(mul_p);
        phase_d = MD_MUL_HI;
      end
      MD_MUL_HI: begin
        prod_d  = prod_q + (PROD_W'(mul_p) << MUL_SPLIT);
        rem_d   = '0;
        quo_d   = '0;
        big_d   = 1'b0;
        cnt_d   = '0;
        phase_d = MD_DIV;
      end
      MD_DIV: begin
        prod_d = prod_q << 1;
        rem_d  = ge ? (rem_shift - div_ext) : rem_shift;
        quo_d  = {quo_q[QUO_W-2:0], ge};
        // Once the quotient has passed the cap it stays there.
        big_d  = big_q | quo_q[QUO_W-1];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          phase_d = MD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    big_q  <= big_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = (big_q || (quo_q > QUO_CAP)) ? QUO_CAP : quo_q;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
      phase_q == MD_DIV |-> rem_q < div_ext)
    else $error("division remainder not below divisor");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      req_i.start |-> phase_q == MD_IDLE)
    else $error("multiply-divide started while busy");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_q |-> phase_q == MD_IDLE)
    else $error("multiply-divide reported done while still busy");
`endif

endmodule

/* hdl/piecewise_linear_table_lookup.sv */
// Piecewise linear lookup in signed Q16.16. A transaction with mode 0 stores one
// table entry (breakpoint x and value y) and is acknowledged with region 3 in the
// next cycle; a transaction with mode 1 looks up query_x in the first table_length
// entries (clamped to 2..TABLE_DEPTH), which must hold ascending breakpoints.
// Queries below the first or above the last breakpoint return the end value with
// region 1 or 2. Otherwise the block binary-searches the table, each halving
// reading through the single read port of the table memory, then reads the
// segment ends and forms y1 + trunc((x - x1) * (y2 - y1) / (x2 - x1)) on one
// shared multiply-divide unit: a multiplication in two slices, then a restoring
// divider. Equal breakpoints skip the division. The input stalls while a
// transaction is in progress or a result is waiting; the result register
// holds one finished result. The user must write table_length through its
// own port only while the block is idle; the block itself does not enforce
// it. Table entries read before they were written give undefined results.
`timescale 1ns / 1ps

module piecewise_linear_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [4:0]         entry_index_i,
  input  logic signed [31:0] entry_x_i,
  input  logic signed [31:0] entry_y_i,
  input  logic signed [31:0] query_x_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_y_o,
  output logic [1:0]         region_o
);

  import plt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W = QUO_W + 2;

  plt_state_e state_q, state_d;

  logic [LEN_W-1:0] table_length_q;

  logic signed [31:0] qx_q, qx_d;
  logic [LW-1:0]      n_q, n_d;
  logic [IW-1:0]      low_q, low_d, high_q, high_d, m_q, m_d, seg_q, seg_d;
  logic signed [31:0] x1_q, x1_d, y1_q, y1_d;
  logic               neg_q, neg_d;
  logic signed [31:0] res_q, res_d;
  logic [1:0]         reg_q, reg_d;

  logic               out_valid_q;
  logic signed [31:0] out_y_q;
  logic [1:0]         out_region_q;
  logic               out_load;
  logic signed [31:0] out_y_next;
  logic [1:0]         out_region_next;
  logic               out_free;

  logic               in_acc;
  logic               wr_en;
  logic [IW-1:0]      rd_addr;
  logic [63:0]        rd_data;
  logic signed [31:0] x_rd, y_rd;

  logic [31:0]        len_full, n_full;
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;

  logic signed [32:0] diff_a, diff_b, diff_d;
  logic               md_start;
  plt_md_req_t        md_req;
  plt_md_rsp_t        md_rsp;

  logic signed [SUM_W-1:0] quo_signed, interp_sum;
  logic                    sat_hi, sat_lo;
  logic signed [31:0]      interp_y;

  // Configuration port is always able to take a transaction.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= TABLE_LENGTH_RESET;
    end else if (cfg_valid_i) begin
      table_length_q <= cfg_data_i;
    end
  end

  // The output register is free when empty or when its result leaves this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Table length in use, clamped to the range the table supports.
  assign len_full = 32'(table_length_q);
  assign n_full   = (len_full < 32'd2) ? 32'd2 :
                    (len_full > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_full;

  // Write indexes beyond the table are acknowledged but not stored.
  assign wr_en = in_acc && (mode_i == MODE_WRITE) && (32'(entry_index_i) < 32'(TABLE_DEPTH));

  plt_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IW'(entry_index_i)),
    .wr_data_i ({entry_x_i, entry_y_i}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign x_rd = $signed(rd_data[63:32]);
  assign y_rd = $signed(rd_data[31:0]);

  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign mid     = mid_sum[IW:1];

  // Operands of the slope term, valid while the upper segment end is on the read port.
  assign diff_a = $signed({qx_q[31], qx_q}) - $signed({x1_q[31], x1_q});
  assign diff_b = $signed({y_rd[31], y_rd}) - $signed({y1_q[31], y1_q});
  assign diff_d = $signed({x_rd[31], x_rd}) - $signed({x1_q[31], x1_q});

  assign md_req.start = md_start;
  assign md_req.a_mag = diff_a[32] ? MAG_W'(-diff_a) : MAG_W'(diff_a);
  assign md_req.b_mag = diff_b[32] ? MAG_W'(-diff_b) : MAG_W'(diff_b);
  assign md_req.d_mag = diff_d[32] ? MAG_W'(-diff_d) : MAG_W'(diff_d);

  plt_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Add the signed, capped quotient to y1 and saturate to 32 bits.
  assign quo_signed = neg_q ? -$signed({2'b00, md_rsp.quo}) : $signed({2'b00, md_rsp.quo});
  assign interp_sum = $signed({{(SUM_W-32){y1_q[31]}}, y1_q}) + quo_signed;
  assign sat_hi     = !interp_sum[SUM_W-1] && (|interp_sum[SUM_W-2:31]);
  assign sat_lo     = interp_sum[SUM_W-1] && !(&interp_sum[SUM_W-2:31]);
  assign interp_y   = sat_hi ? 32'sh7fffffff :
                      sat_lo ? 32'sh80000000 : $signed(interp_sum[31:0]);

  // Sequencer. Each state that sets rd_addr finds the entry on rd_data in the next state.
  always_comb begin
    state_d         = state_q;
    qx_d            = qx_q;
    n_d             = n_q;
    low_d           = low_q;
    high_d          = high_q;
    m_d             = m_q;
    seg_d           = seg_q;
    x1_d            = x1_q;
    y1_d            = y1_q;
    neg_d           = neg_q;
    res_d           = res_q;
    reg_d           = reg_q;
    rd_addr         = '0;
    md_start        = 1'b0;
    out_load        = 1'b0;
    out_y_next      = '0;
    out_region_next = REGION_WRITE;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_WRITE) begin
            out_load        = 1'b1;
            out_y_next      = '0;
            out_region_next = REGION_WRITE;
          end else begin
            qx_d    = query_x_i;
            n_d     = LW'(n_full);
            rd_addr = '0;
            state_d = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (qx_q < x_rd) begin
          res_d   = y_rd;
          reg_d   = REGION_BELOW;
          state_d = S_DONE;
        end else begin
          rd_addr = IW'(n_q - 1'b1);
          state_d = S_CHKN;
        end
      end
      S_CHKN: begin
        if (qx_q > x_rd) begin
          res_d   = y_rd;
          reg_d   = REGION_ABOVE;
          state_d = S_DONE;
        end else begin
          low_d   = '0;
          high_d  = IW'(n_q - 1'b1);
          state_d = S_MID;
        end
      end
      S_MID: begin
        if (low_q > high_q) begin
          // No segment found in a table that is not ascending: use the first.
          seg_d   = '0;
          state_d = S_SEG;
        end else begin
          m_d = mid;
          if ((LW'(mid) + 1'b1) >= n_q) begin
            // Landing on the last entry selects the last segment.
            seg_d   = IW'(n_q - 2'd2);
            state_d = S_SEG;
          end else begin
            rd_addr = mid + 1'b1;
            state_d = S_HI;
          end
        end
      end
      S_HI: begin
        if (qx_q <= x_rd) begin
          rd_addr = m_q;
          state_d = S_LO;
        end else begin
          low_d   = m_q + 1'b1;
          state_d = S_MID;
        end
      end
      S_LO: begin
        if (qx_q >= x_rd) begin
          seg_d   = m_q;
          state_d = S_SEG;
        end else if (high_q == m_q) begin
          seg_d   = '0;
          state_d = S_SEG;
        end else begin
          high_d  = m_q;
          state_d = S_MID;
        end
      end
      S_SEG: begin
        rd_addr = seg_q;
        state_d = S_P1;
      end
      S_P1: begin
        x1_d    = x_rd;
        y1_d    = y_rd;
        rd_addr = seg_q + 1'b1;
        state_d = S_P2;
      end
      S_P2: begin
        if (x1_q == x_rd) begin
          // A vertical segment returns its upper value.
          res_d   = y_rd;
          reg_d   = REGION_INTERP;
          state_d = S_DONE;
        end else begin
          md_start = 1'b1;
          neg_d    = diff_a[32] ^ diff_b[32] ^ diff_d[32];
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (md_rsp.done) begin
          res_d   = interp_y;
          reg_d   = REGION_INTERP;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_y_next      = res_q;
          out_region_next = reg_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q   <= qx_d;
    n_q    <= n_d;
    low_q  <= low_d;
    high_q <= high_d;
    m_q    <= m_d;
    seg_q  <= seg_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    reg_q  <= reg_d;
    if (out_load) begin
      out_y_q      <= out_y_next;
      out_region_q <= out_region_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_y_o  = out_y_q;
  assign region_o    = out_region_q;

`ifndef ASSERT_OFF
  a_md_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
      md_rsp.done |-> state_q == S_DIV)
    else $error("multiply-divide finished outside the divide state");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_SEG |-> (LW'(seg_q) + 1'b1) < n_q)
    else $error("selected segment runs past the table length");

  a_high_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_MID |-> LW'(high_q) < n_q)
    else $error("search bound beyond the table length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while its result waits");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the piecewise linear lookup block. Table-load and
// lookup transactions are queued by the stimulus process, pushed into the
// block by a clocked driver and predicted the moment the block accepts them.
// A clocked monitor pops the oldest prediction for every result transaction
// and compares both result fields. Both sides insert random bubbles, except
// during one long phase where they run flat out.
module testbench;
  import plt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int IDLE_PCT    = 11;
  localparam int QUIET_LIMIT = 5000;   // cycles with no transaction at all
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic        mode;
    logic [4:0]  entry_index;
    logic [31:0] entry_x;
    logic [31:0] entry_y;
    logic [31:0] query_x;
  } request_t;

  typedef struct packed {
    logic [31:0] y;
    logic [1:0]  region;
  } outcome_t;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid   = 1'b0;
  logic     cfg_ready_o;
  logic [5:0] cfg_data  = 6'd0;
  logic     in_valid    = 1'b0;
  logic     in_stall_o;
  request_t in_item     = '0;
  logic     out_valid_o;
  logic     out_stall   = 1'b0;
  logic signed [31:0] result_y_o;
  logic [1:0] region_o;

  // Requests waiting for the driver, and predictions waiting for the monitor.
  request_t pending_items[$];
  outcome_t awaited_results[$];

  // Predictor state: the table as the block should hold it, and the length.
  logic signed [31:0] knot_x [TABLE_DEPTH];
  logic signed [31:0] knot_y [TABLE_DEPTH];
  logic [5:0]         active_len = TABLE_LENGTH_RESET;

  // The stimulus side keeps its own view of the breakpoints so that it can
  // aim queries at real segments.
  logic signed [31:0] plan_x [TABLE_DEPTH];

  logic steady = 1'b0;     // when set, neither side inserts bubbles
  int   errors = 0;
  int   item_total = 0;
  int   quiet = 0;

  piecewise_linear_table_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .mode_i       (in_item.mode),
    .entry_index_i(in_item.entry_index),
    .entry_x_i    (in_item.entry_x),
    .entry_y_i    (in_item.entry_y),
    .query_x_i    (in_item.query_x),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .result_y_o   (result_y_o),
    .region_o     (region_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected result of one accepted transaction. A write updates the table and
  // is acknowledged; a lookup clamps at either end or interpolates in the
  // segment that the binary search settles on.
  function automatic outcome_t lookup_model(input request_t req);
    outcome_t           o;
    logic signed [31:0] qx;
    logic signed [127:0] dx, dy, dd, acc;
    int                 n, lo, hi, m, s;
    logic               found;
    o.y = '0;
    o.region = REGION_WRITE;
    if (req.mode == MODE_WRITE) begin
      knot_x[req.entry_index] = req.entry_x;
      knot_y[req.entry_index] = req.entry_y;
      return o;
    end
    qx = req.query_x;
    n = (active_len < 2) ? 2 : (active_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_len);
    if (qx < knot_x[0]) begin
      o.y = knot_y[0];
      o.region = REGION_BELOW;
    end else if (qx > knot_x[n-1]) begin
      o.y = knot_y[n-1];
      o.region = REGION_ABOVE;
    end else begin
      // The search falls back to segment zero when it gives up, and a probe
      // that lands on the last entry is taken as the last segment.
      lo = 0;
      hi = n - 1;
      s = 0;
      found = 1'b0;
      while (!found && lo <= hi) begin
        m = lo + (hi - lo) / 2;
        if (m + 1 >= n) begin
          s = n - 2;
          found = 1'b1;
        end else if (qx <= knot_x[m+1]) begin
          if (qx >= knot_x[m]) begin
            s = m;
            found = 1'b1;
          end else if (hi == m) begin
            found = 1'b1;
          end else begin
            hi = m;
          end
        end else begin
          lo = m + 1;
        end
      end
      o.region = REGION_INTERP;
      if (knot_x[s] == knot_x[s+1]) begin
        o.y = knot_y[s+1];
      end else begin
        // Full-width product first, then a division that truncates toward
        // zero, then saturation to 32 bits.
        dx = qx - knot_x[s];
        dy = knot_y[s+1] - knot_y[s];
        dd = knot_x[s+1] - knot_x[s];
        acc = knot_y[s] + (dx * dy) / dd;
        if (acc > 128'sd2147483647) acc = 128'sd2147483647;
        if (acc < -128'sd2147483648) acc = -128'sd2147483648;
        o.y = acc[31:0];
      end
    end
    return o;
  endfunction

  // Driver: a new request is presented only when the channel is free or the
  // current one has just been taken, so a stalled payload never moves.
  always @(posedge clk_i) begin : feed
    request_t next_item;
    logic     go;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) awaited_results.push_back(lookup_model(in_item));
      if (!in_valid || !in_stall_o) begin
        go = pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        if (go) begin
          next_item = pending_items.pop_front();
          in_item <= next_item;
        end
        in_valid <= go;
      end
    end
  end

  // Monitor: every result transaction must match the oldest prediction.
  always @(posedge clk_i) begin : check
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result y=%0d region=%0d", $time, result_y_o, region_o);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (result_y_o !== want.y) begin
            $display("%0t: result_y expected %0d got %0d", $time, $signed(want.y),
                     result_y_o);
            errors++;
          end
          if (region_o !== want.region) begin
            $display("%0t: region expected %0d got %0d", $time, want.region, region_o);
            errors++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_write(input int idx, input logic [31:0] x, input logic [31:0] y);
    request_t r;
    r.mode = MODE_WRITE;
    r.entry_index = idx[4:0];
    r.entry_x = x;
    r.entry_y = y;
    r.query_x = $urandom;
    pending_items.push_back(r);
    item_total++;
  endtask

  task automatic send_lookup(input logic [31:0] q);
    request_t r;
    r.mode = MODE_LOOKUP;
    r.entry_index = $urandom;
    r.entry_x = $urandom;
    r.entry_y = $urandom;
    r.query_x = q;
    pending_items.push_back(r);
    item_total++;
  endtask

  // Sampled at the falling edge so that every update of the rising edge has
  // settled: the block is idle once nothing is queued, offered or awaited.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic set_length(input logic [5:0] len);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    active_len = len;
  endtask

  // Loads entries 0..n-1. Style 0 is ascending over the whole range, style 1
  // ascending on a coarse grid (many equal breakpoints), style 2 unsorted.
  task automatic load_table(input int n, input int style);
    logic signed [31:0] v;
    int i, j;
    for (i = 0; i < n; i++) begin
      plan_x[i] = (style == 1) ? (int'($urandom_range(0, 60)) - 30) * 16384 : $urandom;
    end
    if (style != 2) begin
      for (i = 1; i < n; i++) begin
        v = plan_x[i];
        j = i - 1;
        while (j >= 0 && plan_x[j] > v) begin
          plan_x[j+1] = plan_x[j];
          j--;
        end
        plan_x[j+1] = v;
      end
    end
    for (i = 0; i < n; i++) begin
      send_write(i, plan_x[i],
                 $urandom_range(0, 1) ? $urandom : (int'($urandom_range(0, 400)) - 200) * 4096);
    end
  endtask

  // Mostly queries inside a segment or on a breakpoint, some anywhere, and a
  // few stray writes that disturb the table.
  task automatic add_queries(input int n, input int count);
    logic signed [31:0] lo, hi;
    longint unsigned    span, pick;
    int k, r, i;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        i = $urandom_range(0, TABLE_DEPTH - 1);
        plan_x[i] = $urandom;
        send_write(i, plan_x[i], $urandom);
      end else if (r < 25) begin
        send_lookup($urandom);
      end else if (r < 35) begin
        send_lookup(plan_x[$urandom_range(0, n - 1)]);
      end else begin
        i = $urandom_range(0, n - 2);
        lo = plan_x[i];
        hi = plan_x[i+1];
        if (lo <= hi) begin
          span = longint'(hi) - longint'(lo) + 1;
          pick = {$urandom, $urandom};
          send_lookup(32'(longint'(lo) + longint'(pick % span)));
        end else begin
          send_lookup($urandom);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [5:0] lens [8];
    logic [5:0] len;
    int phase, n, r, style;
    lens = '{6'd32, 6'd0, 6'd1, 6'd33, 6'd63, 6'd2, 6'd3, 6'd17};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset length of two entries. Both end values are
    // the extremes, so the slope is as steep as the format allows.
    send_write(0, -65536, 32'h7FFF_FFFF);
    send_write(1, 65536, 32'h8000_0000);
    send_lookup(32'h8000_0000);   // clamped below
    send_lookup(32'h7FFF_FFFF);   // clamped above
    send_lookup(-65536);          // exactly on the first breakpoint
    send_lookup(65536);           // exactly on the last breakpoint
    send_lookup(0);
    send_lookup(12345);
    // Breakpoints at the ends of the range give the widest differences.
    send_write(0, 32'h8000_0000, 32'h8000_0000);
    send_write(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_lookup(32'h8000_0000);
    send_lookup(32'h7FFF_FFFF);
    send_lookup(0);
    send_lookup(32'hFFFF_FFFF);
    // Two equal breakpoints: a hit returns the upper value.
    send_write(0, 100 * 65536, 5 * 65536);
    send_write(1, 100 * 65536, 9 * 65536);
    send_lookup(100 * 65536);
    send_lookup(0);
    send_lookup(32'h7FFF_FFFF);
    send_write(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases. The first one uses all 32 entries and loads every one of
    // them, so no later phase can read an entry that was never written. The
    // third phase is long and runs without bubbles on either side.
    phase = 0;
    while (item_total < RANDOM_ITEMS + 20) begin
      wait_idle();
      steady = (phase == 2);
      len = (phase < 8) ? lens[phase] : 6'($urandom_range(0, 63));
      set_length(len);
      n = (len < 2) ? 2 : (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
      r = $urandom_range(0, 99);
      style = (phase == 0 || r < 60) ? 0 : (r < 85) ? 1 : 2;
      load_table(n, style);
      add_queries(n, (phase == 2) ? 200 : $urandom_range(20, 50));
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
